// File: src/rde_pkg.sv
package rde_pkg;

    localparam int VALUE_W    = 64;
    localparam int PAD_W      = 6;
    localparam int CHAR_W     = 8;
    localparam int TOTAL_W    = 7;
    localparam int RADIX_W    = 5;
    localparam int ALPHA_W    = 64;
    localparam int DIGIT_W    = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;
    localparam int CHUNK_W    = 8;

    localparam int DEF_MAX_BASE    = 16;
    localparam int DEF_VALUE_WIDTH = 64;

    localparam logic [CFG_IDX_W-1:0] REG_RADIX      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA_LOW  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA_HIGH = 2'd2;

    localparam logic [RADIX_W-1:0] RADIX_RESET      = 5'd10;
    localparam logic [ALPHA_W-1:0] ALPHA_LOW_RESET  = 64'h3736353433323130;
    localparam logic [ALPHA_W-1:0] ALPHA_HIGH_RESET = 64'h6665646362613938;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_RD,
        ST_EMIT,
        ST_ERR
    } state_t;

    typedef struct packed {
        logic load;
        logic step;
        logic rd;
        logic next;
        logic err;
    } cmd_t;

    typedef struct packed {
        logic base_bad;
        logic digit_done;
        logic quo_zero;
        logic idx_zero;
    } status_t;

    function automatic logic [CHAR_W-1:0] glyph(
        input logic [ALPHA_W-1:0] alo,
        input logic [ALPHA_W-1:0] ahi,
        input logic [DIGIT_W-1:0] idx
    );
        logic [2*ALPHA_W-1:0] all;
        all = {ahi, alo};
        return all[idx*CHAR_W +: CHAR_W];
    endfunction

endpackage

// File: src/rde_in_if.sv
interface rde_in_if import rde_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] value;
    logic [PAD_W-1:0]   pad_zeros;

    modport source (output valid, value, pad_zeros, input ready);
    modport sink (input valid, value, pad_zeros, output ready);
endinterface

// File: src/rde_out_if.sv
interface rde_out_if import rde_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [CHAR_W-1:0]  character;
    logic [PAD_W-1:0]   zeros_before;
    logic               last;
    logic               error;
    logic [TOTAL_W-1:0] total_count;

    modport source (output valid, character, zeros_before, last, error, total_count,
                    input ready);
    modport sink (input valid, character, zeros_before, last, error, total_count,
                  output ready);
endinterface

// File: src/radix_digit_emitter.sv
// channel | dir | payload                                           | transaction
// din     | in  | value, pad_zeros                                  | valid & ready
// dout    | out | character, zeros_before, last, error, total_count | valid & ready
//
// one number at a time; each digit is worked out chunk by chunk in the
// shared divide stage (8 quotient bits per cycle)
// each character then needs a digit RAM read, then is presented, held under output stall
// a base below two gives a single error transaction in the cycle after accept
// reset loads the register defaults; the digit RAM needs no clearing pass
module radix_digit_emitter import rde_pkg::*; #(
    parameter int MAX_BASE    = DEF_MAX_BASE,
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_en,
    input  logic [CFG_IDX_W-1:0]  wr_index,
    input  logic [CFG_DATA_W-1:0] wr_data,
    rde_in_if.sink                din,
    rde_out_if.source             dout
);

    cmd_t    cmd;
    status_t status;

    rde_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (din.valid),
        .in_ready  (din.ready),
        .out_valid (dout.valid),
        .out_ready (dout.ready),
        .status    (status),
        .cmd       (cmd)
    );

    rde_dp #(
        .MAX_BASE    (MAX_BASE),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .wr_en        (wr_en),
        .wr_index     (wr_index),
        .wr_data      (wr_data),
        .value        (din.value),
        .pad_zeros    (din.pad_zeros),
        .cmd          (cmd),
        .status       (status),
        .character    (dout.character),
        .zeros_before (dout.zeros_before),
        .last         (dout.last),
        .error        (dout.error),
        .total_count  (dout.total_count)
    );

`ifndef SYNTH
    // input side and output side never open together
    assert property (@(posedge clk) disable iff (!rst_n)
        !(din.ready && dout.valid))
        else $error("input ready while a result is pending");

    assert property (@(posedge clk) disable iff (!rst_n)
        (dout.valid && dout.error) |-> dout.last)
        else $error("error transaction not marked last");

    assert property (@(posedge clk) disable iff (!rst_n)
        (dout.valid && !dout.last) |-> (dout.total_count == '0))
        else $error("total count set before last transaction");

    // after a last transaction the block goes back to taking input
    assert property (@(posedge clk) disable iff (!rst_n)
        (dout.valid && dout.ready && dout.last) |=> din.ready)
        else $error("not idle after last transaction");
`endif

endmodule

// File: src/rde_ram.sv
module rde_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: src/rde_ctrl.sv
module rde_ctrl import rde_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    output logic    out_valid,
    input  logic    out_ready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = status.base_bad ? ST_ERR : ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (status.digit_done && status.quo_zero)
                begin
                    state_next = ST_RD;
                end
            end
            ST_RD:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_ready)
                begin
                    state_next = status.idx_zero ? ST_IDLE : ST_RD;
                end
            end
            ST_ERR:
            begin
                if (out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready  = 1'b0;
        out_valid = 1'b0;
        cmd       = '0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_DIV:
            begin
                cmd.step = 1'b1;
            end
            ST_RD:
            begin
                cmd.rd = 1'b1;
            end
            ST_EMIT:
            begin
                out_valid = 1'b1;
                cmd.next  = out_ready && !status.idx_zero;
            end
            ST_ERR:
            begin
                out_valid = 1'b1;
                cmd.err   = 1'b1;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// File: src/rde_dp.sv
module rde_dp import rde_pkg::*; #(
    parameter int MAX_BASE    = DEF_MAX_BASE,
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_en,
    input  logic [CFG_IDX_W-1:0]  wr_index,
    input  logic [CFG_DATA_W-1:0] wr_data,
    input  logic [VALUE_W-1:0]    value,
    input  logic [PAD_W-1:0]      pad_zeros,
    input  cmd_t                  cmd,
    output status_t               status,
    output logic [CHAR_W-1:0]     character,
    output logic [PAD_W-1:0]      zeros_before,
    output logic                  last,
    output logic                  error,
    output logic [TOTAL_W-1:0]    total_count
);

    localparam int STEPS  = (VALUE_WIDTH + CHUNK_W - 1) / CHUNK_W;
    localparam int QW     = STEPS * CHUNK_W;
    localparam int STEP_W = (STEPS > 1) ? $clog2(STEPS) : 1;
    localparam int ADDR_W = $clog2(VALUE_WIDTH);
    localparam int CNT_W  = $clog2(VALUE_WIDTH + 1);

    logic [RADIX_W-1:0] radix_reg;
    logic [ALPHA_W-1:0] alpha_low_reg;
    logic [ALPHA_W-1:0] alpha_high_reg;

    logic [QW-1:0]      quo_reg;
    logic [DIGIT_W-1:0] rem_reg;
    logic [RADIX_W-1:0] base_reg;
    logic [PAD_W-1:0]   pad_reg;
    logic [STEP_W-1:0]  step_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [ADDR_W-1:0]  idx_reg;
    logic               first_reg;

    logic [RADIX_W-1:0] base_sat;
    logic [QW-1:0]      quo_next;
    logic [DIGIT_W-1:0] rem_next;
    logic [CHUNK_W-1:0] qbits;
    logic [DIGIT_W-1:0] digit_rd;
    logic               digit_done;

    // saturate base to the largest supported one
    assign base_sat = (radix_reg > RADIX_W'(MAX_BASE)) ? RADIX_W'(MAX_BASE) : radix_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg      <= RADIX_RESET;
            alpha_low_reg  <= ALPHA_LOW_RESET;
            alpha_high_reg <= ALPHA_HIGH_RESET;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_RADIX:      radix_reg      <= wr_data[RADIX_W-1:0];
                REG_ALPHA_LOW:  alpha_low_reg  <= wr_data[ALPHA_W-1:0];
                REG_ALPHA_HIGH: alpha_high_reg <= wr_data[ALPHA_W-1:0];
                default:        radix_reg      <= radix_reg;
            endcase
        end
    end

    // long division, eight quotient bits per cycle, top chunk first
    always_comb
    begin
        logic [RADIX_W-1:0] r;
        logic [RADIX_W-1:0] t;
        logic [CHUNK_W-1:0] chunk;
        r     = (step_reg == '0) ? '0 : RADIX_W'(rem_reg);
        chunk = quo_reg[QW-1 -: CHUNK_W];
        qbits = '0;
        for (int i = CHUNK_W - 1; i >= 0; i--)
        begin
            t = {r[DIGIT_W-1:0], chunk[i]};
            if (t >= base_reg)
            begin
                r        = t - base_reg;
                qbits[i] = 1'b1;
            end
            else
            begin
                r = t;
            end
        end
        rem_next = r[DIGIT_W-1:0];
        quo_next = (quo_reg << CHUNK_W) | QW'(qbits);
    end

    assign digit_done = (step_reg == STEP_W'(STEPS - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg  <= '0;
            cnt_reg   <= '0;
            idx_reg   <= '0;
            first_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            step_reg  <= '0;
            cnt_reg   <= '0;
            first_reg <= 1'b1;
        end
        else if (cmd.step)
        begin
            step_reg <= digit_done ? '0 : step_reg + 1'b1;
            if (digit_done)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                idx_reg <= cnt_reg[ADDR_W-1:0];
            end
        end
        else if (cmd.next)
        begin
            idx_reg   <= idx_reg - 1'b1;
            first_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            quo_reg  <= QW'(value[VALUE_WIDTH-1:0]);
            base_reg <= base_sat;
            pad_reg  <= pad_zeros;
        end
        else if (cmd.step)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    rde_ram #(
        .WIDTH (DIGIT_W),
        .DEPTH (VALUE_WIDTH)
    ) u_digits (
        .clk   (clk),
        .we    (cmd.step && digit_done),
        .waddr (cnt_reg[ADDR_W-1:0]),
        .wdata (rem_next),
        .re    (cmd.rd),
        .raddr (idx_reg),
        .rdata (digit_rd)
    );

    assign status.base_bad   = (base_sat < RADIX_W'(2));
    assign status.digit_done = digit_done;
    assign status.quo_zero   = (quo_next == '0);
    assign status.idx_zero   = (idx_reg == '0);

    always_comb
    begin
        if (cmd.err)
        begin
            character    = '0;
            zeros_before = '0;
            last         = 1'b1;
            error        = 1'b1;
            total_count  = '0;
        end
        else
        begin
            character    = glyph(alpha_low_reg, alpha_high_reg, digit_rd);
            zeros_before = first_reg ? pad_reg : '0;
            last         = (idx_reg == '0);
            error        = 1'b0;
            total_count  = (idx_reg == '0) ? TOTAL_W'(pad_reg) + TOTAL_W'(cnt_reg) : '0;
        end
    end

endmodule
